@@ src/sgb_pkg.sv @@
// Shared types and constants of the spatial grid binning block.
package sgb_pkg;

    // Width of an edge sum and of a computed cell coordinate.
    localparam int SUM_W = 17;
    // Width of a doubled cell size, the divisor of the cell computation.
    localparam int DIV_W = 16;
    // Width of the configuration write data.
    localparam int CFG_W = 15;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_GRID_COLUMNS = 2'd0,
        CFG_GRID_ROWS    = 2'd1,
        CFG_CELL_SIZE_X  = 2'd2,
        CFG_CELL_SIZE_Y  = 2'd3
    } t_cfg_index;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_CELL_FULL = 2'd3
    } t_status;

endpackage

@@ src/sgb_div.sv @@
// Bit-serial floor divider of a signed edge sum by an unsigned cell span.
module sgb_div
    import sgb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]        i_divisor,
    output logic                    o_busy,
    output logic signed [SUM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic [SUM_W-1:0] r_mag;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W:0]   trial;
    logic             ge;

    // One quotient bit per cycle, restoring form on the magnitude.
    assign trial = {r_rem, r_mag[SUM_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(SUM_W);
            r_neg  <= i_dividend[SUM_W-1];
            r_mag  <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? DIV_W'(trial - {1'b0, r_div}) : trial[DIV_W-1:0];
            r_mag <= {r_mag[SUM_W-2:0], ge};
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Round toward minus infinity for a negative sum.
    assign o_busy     = r_busy;
    assign o_quotient = !r_neg ? $signed(r_mag)
                      : (r_rem != '0) ? $signed(~r_mag) : $signed(~r_mag + SUM_W'(1));

endmodule

@@ src/sgb_ram.sv @@
// Simple dual-port memory with a registered read port.
module sgb_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Write and read in one clocked block; read data appears in the cycle after its address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ src/spatial_grid_binning_top.sv @@
// Top level of the spatial grid binning block: control, registers and memories.
// A word waits on the 17-step cell dividers; an add then writes its new cell row, and a move
// also reads the old cell and scans its slots before the rows are written. One word at a time;
// a held result delays the next word.
// Reset: synchronous, active low; afterwards a clearing pass empties every cell before words
// are taken.
module spatial_grid_binning_top
    import sgb_pkg::*;
#(
    parameter int MAX_BOXES     = 256,
    parameter int CELL_CAPACITY = 8,
    parameter int MAX_GRID_SIDE = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // box_index[7:0], left_edge[23:8], right_edge[39:24], top_edge[55:40],
    // bottom_edge[71:56]
    input  logic [71:0]      i_s_tdata,
    // kind[0]
    input  logic             i_s_tuser,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // assigned_index[7:0], cell_column[24:8], cell_row[41:25], moved[42],
    // outside_grid[43], status[45:44], zero[47:46]
    output logic [47:0]      o_m_tdata,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int IW   = $clog2(MAX_BOXES);
    localparam int CW   = $clog2(MAX_BOXES + 1);
    localparam int NB   = MAX_GRID_SIDE * MAX_GRID_SIDE + 1;
    localparam int BW   = $clog2(NB);
    localparam int FW   = $clog2(CELL_CAPACITY + 1);
    localparam int SIW  = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    localparam int RW   = FW + CELL_CAPACITY * IW;
    localparam int BXW  = 2 * SUM_W;
    localparam logic [BW-1:0] OVERFLOW = BW'(MAX_GRID_SIDE * MAX_GRID_SIDE);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_BKT, S_NRD, S_NCHK,
        S_ORD, S_OLD, S_OSCAN, S_OWR, S_NWR, S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [6:0]       r_grid_columns, r_grid_rows;
    logic [CFG_W-1:0] r_cell_size_x, r_cell_size_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= 7'd16;
            r_grid_rows    <= 7'd16;
            r_cell_size_x  <= CFG_W'(512);
            r_cell_size_y  <= CFG_W'(512);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_GRID_COLUMNS: r_grid_columns <= i_cfg_data[6:0];
                CFG_GRID_ROWS:    r_grid_rows    <= i_cfg_data[6:0];
                CFG_CELL_SIZE_X:  r_cell_size_x  <= i_cfg_data;
                CFG_CELL_SIZE_Y:  r_cell_size_y  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective grid sides and cell spans.
    logic [7:0]       eff_cols, eff_rows;
    logic [DIV_W-1:0] span_x, span_y;

    assign eff_cols = (32'(r_grid_columns) > MAX_GRID_SIDE) ? 8'(MAX_GRID_SIDE)
                                                             : {1'b0, r_grid_columns};
    assign eff_rows = (32'(r_grid_rows) > MAX_GRID_SIDE) ? 8'(MAX_GRID_SIDE)
                                                          : {1'b0, r_grid_rows};
    assign span_x   = {(r_cell_size_x == '0) ? CFG_W'(1) : r_cell_size_x, 1'b0};
    assign span_y   = {(r_cell_size_y == '0) ? CFG_W'(1) : r_cell_size_y, 1'b0};

    // Item registers.
    logic                    r_kind;
    logic [7:0]              r_idx;
    logic signed [SUM_W-1:0] r_cx, r_cy;
    logic                    r_oob, r_old_oob, r_changed;
    logic [BW-1:0]           r_nb, r_ob;
    logic [CW-1:0]           r_count;
    logic [IW-1:0]           r_widx;
    logic [7:0]              r_assigned;
    logic                    r_moved;
    t_status                 r_status;
    logic [FW-1:0]           r_nfill, r_ofill, r_i;
    logic [CELL_CAPACITY-1:0][IW-1:0] r_nslots, r_oslots;
    logic [BW-1:0]           r_clr;
    logic                    r_o_valid;
    logic [47:0]             r_o_data;

    logic accept;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    // Cell dividers, one per axis.
    logic signed [SUM_W-1:0] sum_x, sum_y, quo_x, quo_y;
    logic                    busy_x, busy_y;

    assign sum_x = SUM_W'($signed(i_s_tdata[23:8])) + SUM_W'($signed(i_s_tdata[39:24]));
    assign sum_y = SUM_W'($signed(i_s_tdata[55:40])) + SUM_W'($signed(i_s_tdata[71:56]));

    sgb_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept), .i_dividend(sum_x),
        .i_divisor(span_x), .o_busy(busy_x), .o_quotient(quo_x)
    );
    sgb_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(accept), .i_dividend(sum_y),
        .i_divisor(span_y), .o_busy(busy_y), .o_quotient(quo_y)
    );

    // Stored cell of each box.
    logic           box_we;
    logic [BXW-1:0] box_q;

    assign box_we = (r_state == S_NWR);

    sgb_ram #(.DW(BXW), .DEPTH(MAX_BOXES)) u_box_ram (
        .i_clk(i_clk), .i_we(box_we), .i_waddr(r_widx), .i_wdata({r_cx, r_cy}),
        .i_raddr(IW'(r_idx)), .o_rdata(box_q)
    );

    // Cell rows: fill count over the slot list.
    logic          row_we;
    logic [BW-1:0] row_waddr, row_raddr;
    logic [RW-1:0] row_wdata, row_q;
    logic [CELL_CAPACITY-1:0][IW-1:0] app_slots;

    always_comb begin
        app_slots = r_nslots;
        app_slots[r_nfill[SIW-1:0]] = r_widx;
    end

    always_comb begin
        row_we    = 1'b0;
        row_waddr = r_nb;
        row_wdata = {r_nfill + FW'(1), app_slots};
        case (r_state)
            S_CLEAR: begin
                row_we    = 1'b1;
                row_waddr = r_clr;
                row_wdata = '0;
            end
            S_OWR: begin
                row_we    = 1'b1;
                row_waddr = r_ob;
                row_wdata = {r_ofill, r_oslots};
            end
            S_NWR: row_we = 1'b1;
            default: ;
        endcase
    end

    assign row_raddr = (r_state == S_ORD) ? r_ob : r_nb;

    sgb_ram #(.DW(RW), .DEPTH(NB)) u_row_ram (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(row_waddr), .i_wdata(row_wdata),
        .i_raddr(row_raddr), .o_rdata(row_q)
    );

    // Grid checks and bucket numbers of the new and the stored cell.
    logic signed [SUM_W-1:0] ox, oy;
    logic                    new_out, old_out;
    logic [15:0]             new_lin, old_lin;
    logic [FW-1:0]           q_fill;
    logic                    bad_idx;

    assign ox      = $signed(box_q[BXW-1:SUM_W]);
    assign oy      = $signed(box_q[SUM_W-1:0]);
    assign new_out = r_cx < 0 || r_cy < 0 || r_cx >= $signed({9'b0, eff_cols})
                  || r_cy >= $signed({9'b0, eff_rows});
    assign old_out = ox < 0 || oy < 0 || ox >= $signed({9'b0, eff_cols})
                  || oy >= $signed({9'b0, eff_rows});
    assign new_lin = {8'b0, r_cy[7:0]} * {8'b0, eff_cols} + {8'b0, r_cx[7:0]};
    assign old_lin = {8'b0, oy[7:0]} * {8'b0, eff_cols} + {8'b0, ox[7:0]};
    assign q_fill  = row_q[RW-1 -: FW];
    assign bad_idx = (32'(r_idx) >= 32'(r_count)) || (32'(r_idx) >= MAX_BOXES);

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // A result taken while no new one is loaded empties the output.
            if (o_m_tvalid && i_m_tready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BW'(1);
                    if (r_clr == BW'(NB - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_kind     <= i_s_tuser;
                        r_idx      <= i_s_tdata[7:0];
                        r_assigned <= i_s_tdata[7:0];
                        r_moved    <= 1'b0;
                        r_status   <= ST_OK;
                        r_state    <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (!busy_x && !busy_y) begin
                        r_cx    <= quo_x;
                        r_cy    <= quo_y;
                        r_state <= S_BKT;
                    end
                end
                S_BKT: begin
                    r_oob     <= new_out;
                    r_old_oob <= old_out;
                    r_changed <= (ox != r_cx) || (oy != r_cy);
                    r_nb      <= new_out ? OVERFLOW : BW'(new_lin);
                    r_ob      <= old_out ? OVERFLOW : BW'(old_lin);
                    r_state   <= S_NRD;
                end
                S_NRD: r_state <= S_NCHK;
                S_NCHK: begin
                    r_nfill  <= q_fill;
                    r_nslots <= row_q[CELL_CAPACITY*IW-1:0];
                    r_state  <= S_DONE;
                    if (r_kind) begin
                        if (32'(r_count) >= MAX_BOXES) begin
                            r_status   <= ST_TABLE_FULL;
                            r_assigned <= 8'd0;
                        end else begin
                            r_assigned <= 8'(r_count);
                            r_widx     <= IW'(r_count);
                            if (32'(q_fill) >= CELL_CAPACITY) begin
                                r_status <= ST_CELL_FULL;
                            end else begin
                                r_state <= S_NWR;
                            end
                        end
                    end else if (bad_idx) begin
                        r_status <= ST_BAD_INDEX;
                    end else if (r_changed && (!r_oob || !r_old_oob)) begin
                        r_widx <= IW'(r_idx);
                        if (32'(q_fill) >= CELL_CAPACITY) begin
                            r_status <= ST_CELL_FULL;
                        end else begin
                            r_state <= S_ORD;
                        end
                    end
                end
                S_ORD: r_state <= S_OLD;
                S_OLD: begin
                    r_ofill  <= q_fill;
                    r_oslots <= row_q[CELL_CAPACITY*IW-1:0];
                    r_i      <= '0;
                    r_state  <= S_OSCAN;
                end
                S_OSCAN: begin
                    // Swap-remove: the last entry takes the place of the match.
                    if (r_i >= r_ofill) begin
                        r_state <= S_NWR;
                    end else if (r_oslots[r_i[SIW-1:0]] == r_widx) begin
                        r_oslots[r_i[SIW-1:0]] <= r_oslots[SIW'(r_ofill - FW'(1))];
                        r_ofill <= r_ofill - FW'(1);
                        r_state <= S_OWR;
                    end else begin
                        r_i <= r_i + FW'(1);
                    end
                end
                S_OWR: r_state <= S_NWR;
                S_NWR: begin
                    r_moved <= 1'b1;
                    if (r_kind) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_valid || i_m_tready) begin
                        r_o_valid <= 1'b1;
                        r_o_data  <= {2'b00, r_status, r_oob, r_moved,
                                      r_cy, r_cx, r_assigned};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

`ifndef SYNTHESIS
    // The box count never passes the table size.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_BOXES) else $error("box count above table size");

    // The box count only grows, and by one word at a time.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
        (r_count == $past(r_count) + CW'(1))) else $error("box count jumped");

    // After a word is taken no other is taken until its result is queued.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready) else $error("second word accepted while busy");

    // A cell row is written only while clearing, while removing a box from its old cell or while placing a box.
    a_row_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_we |-> (r_state == S_CLEAR || r_state == S_OWR || r_state == S_NWR))
        else $error("stray cell row write");
`endif

endmodule
